// ===== rtl/core/blhm_pkg.sv =====
// ----------------------------------------------------------------------------
// blhm_pkg
// Types and constants shared by the battery level monitor modules.
// ----------------------------------------------------------------------------
package blhm_pkg;

	localparam int unsigned PCT_W     = 10;
	localparam int unsigned MV_W      = 16;
	localparam int unsigned STAT_W    = 3;
	localparam int unsigned NUM_W     = MV_W + PCT_W;
	localparam int unsigned QUOT_BITS = 10;
	localparam int unsigned CNT_W     = $clog2(QUOT_BITS);
	localparam int unsigned REG_IDX_W = 3;
	localparam int unsigned REG_DAT_W = 16;

	localparam logic [PCT_W-1:0] PCT_MAX = PCT_W'(1000);
	localparam logic signed [15:0] DEADBAND_MA = 16'sd100;

	// supply status codes
	localparam logic [STAT_W-1:0] ST_UNKNOWN      = 3'd0;
	localparam logic [STAT_W-1:0] ST_CHARGING     = 3'd1;
	localparam logic [STAT_W-1:0] ST_DISCHARGING  = 3'd2;
	localparam logic [STAT_W-1:0] ST_NOT_CHARGING = 3'd3;
	localparam logic [STAT_W-1:0] ST_FULL         = 3'd4;

	// input mode codes
	localparam logic [1:0] MODE_RAW   = 2'd0;
	localparam logic [1:0] MODE_STATE = 2'd1;

	// register indexes
	localparam logic [REG_IDX_W-1:0] REG_INPUT_MODE     = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_VOLTAGE_EMPTY  = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_VOLTAGE_FULL   = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_LOW_SET        = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_LOW_CLEAR      = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_CRITICAL_SET   = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_CRITICAL_CLEAR = 3'd6;

	typedef struct packed {
		logic [15:0]        voltage_mv;
		logic               voltage_ok;
		logic signed [15:0] current_ma;
		logic               current_ok;
		logic [9:0]         reported_percent;
		logic               reported_percent_ok;
		logic [2:0]         reported_status;
	} in_item_t;

	typedef struct packed {
		logic [2:0] supply_status;
		logic [9:0] charge_percent;
		logic       charge_percent_ok;
		logic       low_event;
		logic       critical_event;
		logic       low_flag;
		logic       critical_flag;
	} out_item_t;

	typedef struct packed {
		logic [1:0]       input_mode;
		logic [MV_W-1:0]  voltage_empty_mv;
		logic [MV_W-1:0]  voltage_full_mv;
		logic [PCT_W-1:0] low_set_level;
		logic [PCT_W-1:0] low_clear_level;
		logic [PCT_W-1:0] critical_set_level;
		logic [PCT_W-1:0] critical_clear_level;
	} cfg_t;

	// classified sample handed from front to back
	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [PCT_W-1:0]  pct;
		logic              pct_ok;
		logic              div_req;
		logic [NUM_W-1:0]  num;
		logic [MV_W-1:0]   den;
	} work_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_DIV,
		S_DONE
	} back_state_t;

endpackage

// ===== rtl/core/blhm_front.sv =====
// ----------------------------------------------------------------------------
// blhm_front
// Classifies one sample: supply status, direct charge estimate, or the
// numerator and divisor for the voltage mapping.
// ----------------------------------------------------------------------------
module blhm_front import blhm_pkg::*; (
	input  cfg_t     cfg,
	input  in_item_t item,
	output work_t    work
);

	logic signed [15:0] ma;
	logic [STAT_W-1:0]  cur_stat;
	logic [STAT_W-1:0]  rep_stat;
	logic               map_ok;
	logic               map_div;
	logic [PCT_W-1:0]   map_pct;
	logic [MV_W-1:0]    span;
	logic [MV_W-1:0]    diff;

	always_comb begin
		ma = item.current_ma;
		if (ma < -DEADBAND_MA) begin
			cur_stat = ST_CHARGING;
		end else if (ma > DEADBAND_MA) begin
			cur_stat = ST_DISCHARGING;
		end else begin
			cur_stat = ST_NOT_CHARGING;
		end
		rep_stat = (item.reported_status > ST_FULL) ? ST_UNKNOWN : item.reported_status;
	end

	// linear voltage mapping; the middle of the range needs the divider
	always_comb begin
		span    = cfg.voltage_full_mv - cfg.voltage_empty_mv;
		diff    = item.voltage_mv - cfg.voltage_empty_mv;
		map_ok  = item.voltage_ok && (cfg.voltage_full_mv > cfg.voltage_empty_mv);
		map_div = 1'b0;
		map_pct = '0;
		if (item.voltage_mv <= cfg.voltage_empty_mv) begin
			map_pct = '0;
		end else if (item.voltage_mv >= cfg.voltage_full_mv) begin
			map_pct = PCT_MAX;
		end else begin
			map_div = map_ok;
		end
	end

	always_comb begin
		work.status  = ST_DISCHARGING;
		work.pct     = '0;
		work.pct_ok  = 1'b0;
		work.div_req = 1'b0;
		work.num     = NUM_W'(diff) * NUM_W'(PCT_MAX);
		work.den     = span;
		case (cfg.input_mode)
			MODE_RAW: begin
				work.status = item.current_ok ? cur_stat : ST_UNKNOWN;
			end
			MODE_STATE: begin
				work.status = item.current_ok ? cur_stat : rep_stat;
				if (item.reported_percent_ok) begin
					work.pct    = (item.reported_percent > PCT_MAX) ? PCT_MAX
						: item.reported_percent;
					work.pct_ok = 1'b1;
				end else if (map_ok) begin
					work.pct     = map_pct;
					work.pct_ok  = 1'b1;
					work.div_req = map_div;
				end
			end
			default: begin
				if (map_ok) begin
					work.pct     = map_pct;
					work.pct_ok  = 1'b1;
					work.div_req = map_div;
				end
			end
		endcase
	end

endmodule

// ===== rtl/core/blhm_fifo.sv =====
// ----------------------------------------------------------------------------
// blhm_fifo
// Short queue of classified samples between front and back.
// ----------------------------------------------------------------------------
module blhm_fifo import blhm_pkg::*; #(
	parameter int unsigned DEPTH = 2
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  wr,
	input  work_t wr_data,
	output logic  full,
	input  logic  rd,
	output work_t rd_data,
	output logic  empty
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W_Q = $clog2(DEPTH + 1);

	work_t              slot_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W_Q-1:0] count_q;
	logic               do_wr;
	logic               do_rd;

	assign full    = (count_q == CNT_W_Q'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr && !full;
	assign do_rd   = rd && !empty;
	assign rd_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/core/blhm_back.sv =====
// ----------------------------------------------------------------------------
// blhm_back
// Runs the bit-serial divider when needed, updates the low and critical
// latches and holds the result for transfer.
// ----------------------------------------------------------------------------
module blhm_back import blhm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  logic      work_empty,
	input  work_t     work,
	output logic      work_pop,
	output logic      empty,
	input  logic      pop,
	output out_item_t out_item
);

	back_state_t       state_q;
	back_state_t       state_nxt;
	logic [STAT_W-1:0] status_q;
	logic [PCT_W-1:0]  pct_q;
	logic              pct_ok_q;
	logic [MV_W-1:0]   rem_q;
	logic [MV_W-1:0]   den_q;
	logic [QUOT_BITS-1:0] num_lo_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              low_latch_q;
	logic              crit_latch_q;
	logic              out_valid_q;
	out_item_t         out_q;

	logic              load;
	logic              step;
	logic              done_fire;
	logic [MV_W:0]     trial;
	logic              trial_ge;
	logic [MV_W-1:0]   rem_nxt;
	logic              low_nxt;
	logic              crit_nxt;
	logic              low_ev;
	logic              crit_ev;

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (!work_empty) begin
					state_nxt = work.div_req ? S_DIV : S_DONE;
				end
			end
			S_DIV: begin
				if (cnt_q == CNT_W'(QUOT_BITS - 1)) begin
					state_nxt = S_DONE;
				end
			end
			S_DONE: begin
				if (!out_valid_q || pop) begin
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		load      = 1'b0;
		step      = 1'b0;
		done_fire = 1'b0;
		unique case (state_q)
			S_IDLE:  load      = !work_empty;
			S_DIV:   step      = 1'b1;
			S_DONE:  done_fire = !out_valid_q || pop;
			default: ;
		endcase
	end

	assign work_pop = load;

	// restoring division step; remainder always stays below the divisor
	always_comb begin
		trial    = {rem_q, num_lo_q[QUOT_BITS-1]};
		trial_ge = trial >= {1'b0, den_q};
		rem_nxt  = trial_ge ? MV_W'(trial - {1'b0, den_q}) : trial[MV_W-1:0];
	end

	// latch update
	always_comb begin
		low_nxt  = low_latch_q;
		crit_nxt = crit_latch_q;
		low_ev   = 1'b0;
		crit_ev  = 1'b0;
		if (status_q == ST_CHARGING || status_q == ST_FULL) begin
			low_nxt  = 1'b0;
			crit_nxt = 1'b0;
		end else if (status_q != ST_DISCHARGING) begin
			if (pct_ok_q && pct_q > cfg.low_clear_level) begin
				low_nxt = 1'b0;
			end
			if (pct_ok_q && pct_q > cfg.critical_clear_level) begin
				crit_nxt = 1'b0;
			end
		end else if (pct_ok_q) begin
			if (pct_q < cfg.critical_set_level) begin
				// critical skips the low check
				if (!crit_latch_q) begin
					crit_ev  = 1'b1;
					crit_nxt = 1'b1;
				end
			end else begin
				if (pct_q > cfg.critical_clear_level) begin
					crit_nxt = 1'b0;
				end
				if (pct_q < cfg.low_set_level) begin
					if (!low_latch_q) begin
						low_ev  = 1'b1;
						low_nxt = 1'b1;
					end
				end else if (pct_q > cfg.low_clear_level) begin
					low_nxt = 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			status_q <= work.status;
			pct_q    <= work.pct;
			pct_ok_q <= work.pct_ok;
			den_q    <= work.den;
			rem_q    <= work.num[NUM_W-1:QUOT_BITS];
			num_lo_q <= work.num[QUOT_BITS-1:0];
		end else if (step) begin
			rem_q    <= rem_nxt;
			num_lo_q <= {num_lo_q[QUOT_BITS-2:0], 1'b0};
			pct_q    <= {pct_q[PCT_W-2:0], trial_ge};
		end
		if (done_fire) begin
			out_q.supply_status     <= status_q;
			out_q.charge_percent    <= pct_q;
			out_q.charge_percent_ok <= pct_ok_q;
			out_q.low_event         <= low_ev;
			out_q.critical_event    <= crit_ev;
			out_q.low_flag          <= low_nxt;
			out_q.critical_flag     <= crit_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cnt_q        <= '0;
			low_latch_q  <= 1'b0;
			crit_latch_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (load) begin
				cnt_q <= '0;
			end else if (step) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (done_fire) begin
				low_latch_q  <= low_nxt;
				crit_latch_q <= crit_nxt;
				out_valid_q  <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign empty    = !out_valid_q;
	assign out_item = out_q;

endmodule

// ===== rtl/core/battery_level_hysteresis_monitor_top.sv =====
// ----------------------------------------------------------------------------
// battery_level_hysteresis_monitor_top
// Battery charge estimate with low and critical alarms and hysteresis.
//
//   channel   handshake        payload
//   input     push / full      in_item  (in_item_t)
//   result    empty / pop      out_item (out_item_t)
//   config    wr_en            wr_index, wr_data
//
// A sample that needs the voltage division passes through the back end
// as load, 10 divider steps, then the result; others skip the steps.
// The 10-step restoring divider sets the rate for mapped samples.
// The front takes new samples into the queue while the back is busy.
// Reset clears both latches and loads the register defaults.
// ----------------------------------------------------------------------------
module battery_level_hysteresis_monitor_top import blhm_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  in_item_t             in_item,
	output logic                 empty,
	input  logic                 pop,
	output out_item_t            out_item,
	input  logic                 wr_en,
	input  logic [REG_IDX_W-1:0] wr_index,
	input  logic [REG_DAT_W-1:0] wr_data
);

	cfg_t  cfg_q;
	work_t work_in;
	work_t work_out;
	logic  work_empty;
	logic  work_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.input_mode           <= MODE_RAW;
			cfg_q.voltage_empty_mv     <= MV_W'(9000);
			cfg_q.voltage_full_mv      <= MV_W'(12600);
			cfg_q.low_set_level        <= PCT_W'(300);
			cfg_q.low_clear_level      <= PCT_W'(350);
			cfg_q.critical_set_level   <= PCT_W'(50);
			cfg_q.critical_clear_level <= PCT_W'(80);
		end else if (wr_en) begin
			unique case (wr_index)
				REG_INPUT_MODE:     cfg_q.input_mode           <= wr_data[1:0];
				REG_VOLTAGE_EMPTY:  cfg_q.voltage_empty_mv     <= wr_data;
				REG_VOLTAGE_FULL:   cfg_q.voltage_full_mv      <= wr_data;
				REG_LOW_SET:        cfg_q.low_set_level        <= wr_data[PCT_W-1:0];
				REG_LOW_CLEAR:      cfg_q.low_clear_level      <= wr_data[PCT_W-1:0];
				REG_CRITICAL_SET:   cfg_q.critical_set_level   <= wr_data[PCT_W-1:0];
				REG_CRITICAL_CLEAR: cfg_q.critical_clear_level <= wr_data[PCT_W-1:0];
				default: ;
			endcase
		end
	end

	blhm_front u_front (
		.cfg  (cfg_q),
		.item (in_item),
		.work (work_in)
	);

	blhm_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (push),
		.wr_data (work_in),
		.full    (full),
		.rd      (work_pop),
		.rd_data (work_out),
		.empty   (work_empty)
	);

	blhm_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.work_empty (work_empty),
		.work       (work_out),
		.work_pop   (work_pop),
		.empty      (empty),
		.pop        (pop),
		.out_item   (out_item)
	);

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the battery level monitor. Samples go in through
// the push/full queue port and readings come back through empty/pop. Each
// accepted sample is run through a local model of the status, charge estimate
// and low/critical latches, and every popped reading is compared with the
// oldest prediction. Directed cases come first, then random phases over raw,
// state, voltage and spare modes, extreme and random register settings, random gaps
// on both sides and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top;
	import blhm_pkg::*;

	localparam logic [1:0] MODE_VOLTAGE = 2'd2;
	localparam logic [1:0] MODE_SPARE   = 2'd3;
	localparam int HOLD_CYCLES = 400;
	localparam int MAX_REPORTS = 10;

	logic                 clk;
	logic                 arst_n;
	logic                 push;
	logic                 full;
	in_item_t             in_item;
	logic                 empty;
	logic                 pop;
	out_item_t            out_item;
	logic                 wr_en;
	logic [REG_IDX_W-1:0] wr_index;
	logic [REG_DAT_W-1:0] wr_data;

	// local copy of the monitor state
	cfg_t      mon_cfg;
	logic      low_alarm;
	logic      crit_alarm;
	out_item_t pending_readings[$];

	int errors;
	bit tx_idle;
	bit rx_idle;
	bit hold_req;
	int walk_pct;

	battery_level_hysteresis_monitor_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.in_item  (in_item),
		.empty    (empty),
		.pop      (pop),
		.out_item (out_item),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#4000000;
		$display("battery_level_hysteresis_monitor_top regression: fail");
		$finish;
	end

	// ------------------------------------------------------------------------
	// prediction
	// ------------------------------------------------------------------------
	function automatic logic [STAT_W-1:0] status_of_current(logic signed [15:0] ma);
		if (int'(ma) < -int'(DEADBAND_MA))
			return ST_CHARGING;
		if (int'(ma) > int'(DEADBAND_MA))
			return ST_DISCHARGING;
		return ST_NOT_CHARGING;
	endfunction

	function automatic bit map_voltage(input logic [MV_W-1:0] mv, output logic [PCT_W-1:0] pct);
		int unsigned lo;
		int unsigned hi;
		lo = 32'(mon_cfg.voltage_empty_mv);
		hi = 32'(mon_cfg.voltage_full_mv);
		pct = '0;
		if (hi <= lo)
			return 1'b0;
		if (mv <= lo)
			pct = '0;
		else if (mv >= hi)
			pct = PCT_MAX;
		else
			pct = PCT_W'((mv - lo) * 32'd1000 / (hi - lo));
		return 1'b1;
	endfunction

	function automatic out_item_t predict_reading(in_item_t s);
		out_item_t         r;
		logic [STAT_W-1:0] rstat;
		logic [STAT_W-1:0] status;
		logic [PCT_W-1:0]  pct;
		bit                pct_ok;
		r = '0;
		pct = '0;
		pct_ok = 1'b0;
		rstat = (s.reported_status > ST_FULL) ? ST_UNKNOWN : s.reported_status;
		case (mon_cfg.input_mode)
			MODE_RAW: begin
				status = s.current_ok ? status_of_current(s.current_ma) : ST_UNKNOWN;
			end
			MODE_STATE: begin
				if (s.reported_percent_ok) begin
					pct = (s.reported_percent > PCT_MAX) ? PCT_MAX : s.reported_percent;
					pct_ok = 1'b1;
				end else if (s.voltage_ok) begin
					pct_ok = map_voltage(s.voltage_mv, pct);
				end
				status = s.current_ok ? status_of_current(s.current_ma) : rstat;
			end
			default: begin
				if (s.voltage_ok)
					pct_ok = map_voltage(s.voltage_mv, pct);
				status = ST_DISCHARGING;
			end
		endcase
		if (!pct_ok)
			pct = '0;

		if (status == ST_CHARGING || status == ST_FULL) begin
			low_alarm = 1'b0;
			crit_alarm = 1'b0;
		end else if (status != ST_DISCHARGING) begin
			// unknown / not charging can only clear
			if (pct_ok && pct > mon_cfg.low_clear_level)
				low_alarm = 1'b0;
			if (pct_ok && pct > mon_cfg.critical_clear_level)
				crit_alarm = 1'b0;
		end else if (pct_ok) begin
			if (pct < mon_cfg.critical_set_level) begin
				// critical wins, low check skipped
				if (!crit_alarm) begin
					r.critical_event = 1'b1;
					crit_alarm = 1'b1;
				end
			end else begin
				if (pct > mon_cfg.critical_clear_level)
					crit_alarm = 1'b0;
				if (pct < mon_cfg.low_set_level) begin
					if (!low_alarm) begin
						r.low_event = 1'b1;
						low_alarm = 1'b1;
					end
				end else if (pct > mon_cfg.low_clear_level) begin
					low_alarm = 1'b0;
				end
			end
		end

		r.supply_status = status;
		r.charge_percent = pct;
		r.charge_percent_ok = pct_ok;
		r.low_flag = low_alarm;
		r.critical_flag = crit_alarm;
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------------
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic in_item_t mk_sample(int mv, bit v_ok, int ma, bit c_ok,
			int rpct, bit r_ok, logic [STAT_W-1:0] rstat);
		in_item_t s;
		s.voltage_mv = MV_W'(mv);
		s.voltage_ok = v_ok;
		s.current_ma = 16'(ma);
		s.current_ok = c_ok;
		s.reported_percent = PCT_W'(rpct);
		s.reported_percent_ok = r_ok;
		s.reported_status = rstat;
		return s;
	endfunction

	// charge follows a random walk so the thresholds get crossed both ways
	function automatic in_item_t rand_sample();
		in_item_t s;
		int       r;
		int       span;
		int       mv;
		int       ma;
		if ($urandom_range(0, 19) == 0)
			walk_pct = $urandom_range(0, 1000);
		else
			walk_pct = walk_pct + int'($urandom_range(0, 80)) - 40;
		if (walk_pct < -50)
			walk_pct = -50;
		if (walk_pct > 1050)
			walk_pct = 1050;

		span = int'(mon_cfg.voltage_full_mv) - int'(mon_cfg.voltage_empty_mv);
		r = $urandom_range(0, 99);
		if (r < 70 && span > 0) begin
			mv = int'(mon_cfg.voltage_empty_mv) + walk_pct * span / 1000;
		end else if (r < 85) begin
			mv = $urandom_range(0, 65535);
		end else begin
			case ($urandom_range(0, 3))
				0: mv = 0;
				1: mv = 65535;
				2: mv = int'(mon_cfg.voltage_empty_mv);
				default: mv = int'(mon_cfg.voltage_full_mv);
			endcase
		end
		if (mv < 0)
			mv = 0;
		if (mv > 65535)
			mv = 65535;

		r = $urandom_range(0, 99);
		if (r < 55)
			ma = $urandom_range(101, 5000);
		else if (r < 70)
			ma = -int'($urandom_range(101, 5000));
		else if (r < 82)
			ma = int'($urandom_range(0, 200)) - 100;
		else
			ma = int'($urandom_range(0, 65535)) - 32768;

		s.voltage_mv = MV_W'(mv);
		s.voltage_ok = ($urandom_range(0, 9) != 0);
		s.current_ma = 16'(ma);
		s.current_ok = ($urandom_range(0, 4) != 0);
		if ($urandom_range(0, 99) < 75)
			s.reported_percent = PCT_W'((walk_pct < 0) ? 0 : (walk_pct > 1000) ? 1000 : walk_pct);
		else
			s.reported_percent = PCT_W'($urandom_range(0, 1023));
		s.reported_percent_ok = ($urandom_range(0, 2) != 0);
		if ($urandom_range(0, 99) < 45)
			s.reported_status = ST_DISCHARGING;
		else
			s.reported_status = STAT_W'($urandom_range(0, 7));
		return s;
	endfunction

	function automatic cfg_t default_cfg(logic [1:0] mode);
		cfg_t c;
		c.input_mode = mode;
		c.voltage_empty_mv = 16'd9000;
		c.voltage_full_mv = 16'd12600;
		c.low_set_level = 10'd300;
		c.low_clear_level = 10'd350;
		c.critical_set_level = 10'd50;
		c.critical_clear_level = 10'd80;
		return c;
	endfunction

	function automatic cfg_t normal_cfg(logic [1:0] mode);
		cfg_t c;
		int   lvl;
		c.input_mode = mode;
		c.voltage_empty_mv = MV_W'($urandom_range(6000, 12000));
		c.voltage_full_mv = MV_W'(int'(c.voltage_empty_mv) + int'($urandom_range(500, 6000)));
		c.critical_set_level = PCT_W'($urandom_range(0, 300));
		c.critical_clear_level = PCT_W'(int'(c.critical_set_level) + int'($urandom_range(0, 100)));
		c.low_set_level = PCT_W'($urandom_range(c.critical_set_level, 700));
		lvl = int'(c.low_set_level) + int'($urandom_range(0, 150));
		c.low_clear_level = PCT_W'(lvl);
		return c;
	endfunction

	function automatic cfg_t wild_cfg();
		cfg_t c;
		c.input_mode = 2'($urandom);
		c.voltage_empty_mv = MV_W'($urandom);
		c.voltage_full_mv = MV_W'($urandom);
		c.low_set_level = PCT_W'($urandom);
		c.low_clear_level = PCT_W'($urandom);
		c.critical_set_level = PCT_W'($urandom);
		c.critical_clear_level = PCT_W'($urandom);
		return c;
	endfunction

	task automatic send_sample(in_item_t s);
		int gap;
		gap = tx_idle ? pick_gap() : 0;
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		in_item <= s;
		do
			@(posedge clk);
		while (full);
		pending_readings = {pending_readings, predict_reading(s)};
	endtask

	task automatic wait_idle();
		push <= 1'b0;
		while (pending_readings.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [REG_DAT_W-1:0] data);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= data;
		@(posedge clk);
	endtask

	// unused upper data bits carry junk, the block must mask them
	task automatic apply_cfg(cfg_t c);
		wait_idle();
		write_reg(REG_INPUT_MODE, {14'($urandom), c.input_mode});
		write_reg(REG_VOLTAGE_EMPTY, c.voltage_empty_mv);
		write_reg(REG_VOLTAGE_FULL, c.voltage_full_mv);
		write_reg(REG_LOW_SET, {6'($urandom), c.low_set_level});
		write_reg(REG_LOW_CLEAR, {6'($urandom), c.low_clear_level});
		write_reg(REG_CRITICAL_SET, {6'($urandom), c.critical_set_level});
		write_reg(REG_CRITICAL_CLEAR, {6'($urandom), c.critical_clear_level});
		wr_en <= 1'b0;
		mon_cfg = c;
	endtask

	task automatic note_failure(string msg);
		errors++;
		if (errors <= MAX_REPORTS)
			$display("ERROR @%0t: %s", $realtime, msg);
	endtask

	// ------------------------------------------------------------------------
	// result side: pop with random stalls, check every transfer
	// ------------------------------------------------------------------------
	initial begin
		int        stall;
		int        hold_left;
		bit        hold_seen;
		out_item_t want;
		pop <= 1'b0;
		stall = 0;
		hold_left = 0;
		hold_seen = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && pop && !empty) begin
				if (pending_readings.size() == 0) begin
					note_failure("reading popped with nothing outstanding");
				end else begin
					want = pending_readings.pop_front();
					if (out_item.supply_status !== want.supply_status ||
							out_item.charge_percent !== want.charge_percent ||
							out_item.charge_percent_ok !== want.charge_percent_ok ||
							out_item.low_event !== want.low_event ||
							out_item.critical_event !== want.critical_event ||
							out_item.low_flag !== want.low_flag ||
							out_item.critical_flag !== want.critical_flag)
						note_failure({$sformatf(
							"reading exp st=%0d pct=%0d ok=%b lev=%b cev=%b lf=%b cf=%b",
							want.supply_status, want.charge_percent, want.charge_percent_ok,
							want.low_event, want.critical_event, want.low_flag,
							want.critical_flag), $sformatf(
							" got st=%0d pct=%0d ok=%b lev=%b cev=%b lf=%b cf=%b",
							out_item.supply_status, out_item.charge_percent,
							out_item.charge_percent_ok, out_item.low_event,
							out_item.critical_event, out_item.low_flag,
							out_item.critical_flag)});
				end
			end
			if (hold_seen != hold_req) begin
				hold_seen = hold_req;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else if (stall > 0) begin
				stall--;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
				if (rx_idle)
					stall = pick_gap();
			end
		end
	end

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------
	task automatic test_raw_status();
		apply_cfg(default_cfg(MODE_RAW));
		send_sample(mk_sample(12000, 1, -32768, 1, 500, 1, ST_DISCHARGING));
		send_sample(mk_sample(12000, 1, -101, 1, 500, 1, ST_DISCHARGING));
		send_sample(mk_sample(0, 0, -100, 1, 0, 0, ST_FULL));
		send_sample(mk_sample(65535, 1, 100, 1, 1023, 1, ST_CHARGING));
		send_sample(mk_sample(9000, 1, 101, 1, 10, 1, ST_UNKNOWN));
		send_sample(mk_sample(9000, 1, 32767, 1, 10, 1, ST_NOT_CHARGING));
		send_sample(mk_sample(9000, 1, 32767, 0, 10, 1, 3'd7));
	endtask

	task automatic test_voltage_map();
		apply_cfg(default_cfg(MODE_VOLTAGE));
		send_sample(mk_sample(12600, 1, -5000, 1, 0, 0, ST_CHARGING));
		send_sample(mk_sample(10000, 1, 0, 0, 0, 0, ST_FULL));     // low transfer event
		send_sample(mk_sample(9900, 1, 0, 0, 0, 0, ST_FULL));      // latched, no event
		send_sample(mk_sample(9100, 1, 0, 0, 0, 0, ST_FULL));      // critical, low skipped
		send_sample(mk_sample(9000, 1, 0, 0, 0, 0, ST_FULL));
		send_sample(mk_sample(0, 0, 0, 0, 0, 0, ST_FULL));         // no estimate, latches kept
		send_sample(mk_sample(9500, 1, 0, 0, 0, 0, ST_FULL));      // critical clears only
		send_sample(mk_sample(12599, 1, 0, 0, 0, 0, ST_FULL));
		send_sample(mk_sample(65535, 1, 0, 0, 0, 0, ST_FULL));
	endtask

	task automatic test_state_input();
		apply_cfg(default_cfg(MODE_STATE));
		send_sample(mk_sample(0, 0, 0, 0, 1023, 1, ST_DISCHARGING));    // saturates
		send_sample(mk_sample(0, 0, 0, 0, 20, 1, ST_DISCHARGING));
		send_sample(mk_sample(9000, 1, 0, 0, 900, 0, ST_DISCHARGING));  // falls back to voltage
		send_sample(mk_sample(0, 0, 0, 0, 500, 1, ST_NOT_CHARGING));
		send_sample(mk_sample(0, 0, 0, 0, 10, 1, ST_DISCHARGING));
		send_sample(mk_sample(0, 0, 0, 0, 10, 1, 3'd7));                // bad status -> unknown
		send_sample(mk_sample(0, 0, 0, 0, 10, 1, ST_CHARGING));
		send_sample(mk_sample(0, 0, 0, 0, 10, 1, ST_FULL));
		send_sample(mk_sample(0, 0, -500, 1, 10, 1, ST_DISCHARGING));   // current overrides
	endtask

	// receiver stops for a long stretch while the sender keeps pushing
	task automatic test_backpressure();
		apply_cfg(normal_cfg(MODE_VOLTAGE));
		hold_req = ~hold_req;
		@(posedge clk);
		tx_idle = 1'b0;
		repeat (12) send_sample(rand_sample());
		tx_idle = 1'b1;
	endtask

	task automatic test_random(cfg_t c, int count, bit tx_gaps, bit rx_gaps);
		apply_cfg(c);
		tx_idle = tx_gaps;
		rx_idle = rx_gaps;
		walk_pct = $urandom_range(0, 1000);
		repeat (count) send_sample(rand_sample());
	endtask

	task automatic test_extreme_cfgs();
		cfg_t c;
		c = default_cfg(MODE_VOLTAGE);
		c.voltage_empty_mv = 16'd0;
		c.voltage_full_mv = 16'hFFFF;
		c.low_set_level = 10'd1023;
		c.low_clear_level = 10'd1023;
		c.critical_set_level = 10'd0;
		c.critical_clear_level = 10'd0;
		test_random(c, 50, 0, 0);
		c = default_cfg(MODE_STATE);
		c.voltage_empty_mv = 16'hFFFF;
		c.voltage_full_mv = 16'd0;
		c.low_set_level = 10'd0;
		c.low_clear_level = 10'd0;
		c.critical_set_level = 10'd1000;
		c.critical_clear_level = 10'd1000;
		test_random(c, 50, 1, 1);
	endtask

	task automatic test_random_cfgs();
		repeat (3) test_random(wild_cfg(), 40, 1, 1);
	endtask

	initial begin
		arst_n <= 1'b0;
		push <= 1'b0;
		in_item <= '0;
		wr_en <= 1'b0;
		wr_index <= '0;
		wr_data <= '0;
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		hold_req = 1'b0;
		errors = 0;
		low_alarm = 1'b0;
		crit_alarm = 1'b0;
		walk_pct = 500;
		mon_cfg = default_cfg(MODE_RAW);
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_raw_status();
		test_voltage_map();
		test_state_input();
		test_backpressure();
		test_random(normal_cfg(MODE_RAW), 90, 1, 1);
		test_random(normal_cfg(MODE_STATE), 110, 1, 1);
		test_random(normal_cfg(MODE_VOLTAGE), 110, 1, 1);
		test_extreme_cfgs();
		test_random(normal_cfg(MODE_SPARE), 80, 0, 0);
		test_random_cfgs();

		rx_idle = 1'b0;
		wait_idle();
		repeat (40) @(posedge clk);
		if (errors == 0 && pending_readings.size() == 0)
			$display("battery_level_hysteresis_monitor_top regression: pass");
		else
			$display("battery_level_hysteresis_monitor_top regression: fail");
		$finish;
	end

endmodule
